FILE: rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants for the Q24.8 fixed-point ALU
// Operation codes, data widths and the words passed between stages.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int unsigned DataWidth       = 32;
  localparam int unsigned OpWidth         = 4;
  localparam int unsigned FracBitsDefault = 8;
  localparam int unsigned DivStepBits     = 2;

  typedef enum logic [OpWidth-1:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_e;

  typedef logic signed [DataWidth-1:0] data_t;

  typedef struct packed {
    logic  is_div;
    logic  neg;
    logic  dz;
    logic  cond;
    data_t res;
  } side_t;

  typedef struct packed {
    data_t result;
    logic  condition;
    logic  divide_by_zero;
  } rsp_t;

endpackage

FILE: rtl/fpa_if.sv
// ----------------------------------------------------------------------------
// fpa_req_if / fpa_rsp_if: valid/ready channels of the fixed-point ALU
// Request carries the operation and two operands, response the result.
// ----------------------------------------------------------------------------
interface fpa_req_if;
  import fpa_pkg::*;

  logic  valid;
  logic  ready;
  op_e   operation;
  data_t operand_a;
  data_t operand_b;

  modport source (output valid, output operation, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input operation, input operand_a, input operand_b,
                  output ready);
endinterface

interface fpa_rsp_if;
  import fpa_pkg::*;

  logic  valid;
  logic  ready;
  data_t result;
  logic  condition;
  logic  divide_by_zero;

  modport source (output valid, output result, output condition, output divide_by_zero,
                  input ready);
  modport sink   (input valid, input result, input condition, input divide_by_zero,
                  output ready);
endinterface

FILE: rtl/fpa_prep.sv
// ----------------------------------------------------------------------------
// fpa_prep: first pipeline stage
// Resolves the non-dividing operations, forms the product and sets up the
// unsigned numerator and divisor for the divider.
// ----------------------------------------------------------------------------
module fpa_prep #(
  parameter int unsigned FracBits = fpa_pkg::FracBitsDefault,
  parameter int unsigned NumW     = 40
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  fpa_pkg::op_e                operation_i,
  input  fpa_pkg::data_t              operand_a_i,
  input  fpa_pkg::data_t              operand_b_i,
  output logic                        valid_o,
  output fpa_pkg::side_t              side_o,
  output logic                        is_mul_o,
  output logic signed [2*fpa_pkg::DataWidth-1:0] prod_o,
  output logic [NumW-1:0]             num_o,
  output logic [fpa_pkg::DataWidth-1:0] den_o
);
  import fpa_pkg::*;

  logic                          valid_q;
  side_t                         side_d, side_q;
  logic                          is_mul_q;
  logic signed [2*DataWidth-1:0] prod_d, prod_q;
  logic [NumW-1:0]               num_d, num_q;
  logic [DataWidth-1:0]          den_d, den_q;
  logic [DataWidth-1:0]          abs_a;
  logic                          b_zero;

  assign abs_a  = operand_a_i[DataWidth-1] ? DataWidth'(-operand_a_i) : operand_a_i;
  assign den_d  = operand_b_i[DataWidth-1] ? DataWidth'(-operand_b_i) : operand_b_i;
  assign b_zero = (operand_b_i == '0);
  assign num_d  = NumW'(abs_a) << FracBits;
  assign prod_d = operand_a_i * operand_b_i;

  always_comb begin
    side_d        = '0;
    side_d.neg    = operand_a_i[DataWidth-1] ^ operand_b_i[DataWidth-1];
    unique case (operation_i)
      OP_ADD:      side_d.res = operand_a_i + operand_b_i;
      OP_SUB:      side_d.res = operand_a_i - operand_b_i;
      OP_MUL:      side_d.res = '0;
      OP_DIV: begin
        side_d.is_div = !b_zero;
        side_d.dz     = b_zero;
      end
      OP_GT:       side_d.cond = (operand_a_i >  operand_b_i);
      OP_LT:       side_d.cond = (operand_a_i <  operand_b_i);
      OP_GE:       side_d.cond = (operand_a_i >= operand_b_i);
      OP_LE:       side_d.cond = (operand_a_i <= operand_b_i);
      OP_EQ:       side_d.cond = (operand_a_i == operand_b_i);
      OP_NE:       side_d.cond = (operand_a_i != operand_b_i);
      OP_MIN:      side_d.res = (operand_a_i < operand_b_i) ? operand_a_i : operand_b_i;
      OP_MAX:      side_d.res = (operand_a_i > operand_b_i) ? operand_a_i : operand_b_i;
      OP_INC:      side_d.res = operand_a_i + data_t'(1);
      OP_DEC:      side_d.res = operand_a_i - data_t'(1);
      OP_FROM_INT: side_d.res = operand_a_i <<< FracBits;
      OP_TO_INT:   side_d.res = operand_a_i >>> FracBits;
      default:     side_d.res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side_q   <= side_d;
      is_mul_q <= (operation_i == OP_MUL);
      prod_q   <= prod_d;
      num_q    <= num_d;
      den_q    <= den_d;
    end
  end

  assign valid_o  = valid_q;
  assign side_o   = side_q;
  assign is_mul_o = is_mul_q;
  assign prod_o   = prod_q;
  assign num_o    = num_q;
  assign den_o    = den_q;

endmodule

FILE: rtl/fpa_div_stage.sv
// ----------------------------------------------------------------------------
// fpa_div_stage: one stage of the restoring divider
// Retires DivStepBits quotient bits per stage; side data rides along.
// ----------------------------------------------------------------------------
module fpa_div_stage #(
  parameter int unsigned NumW = 40
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  fpa_pkg::side_t                side_i,
  input  logic [NumW-1:0]               nq_i,
  input  logic [fpa_pkg::DataWidth-1:0] rem_i,
  input  logic [fpa_pkg::DataWidth-1:0] den_i,
  output logic                          valid_o,
  output fpa_pkg::side_t                side_o,
  output logic [NumW-1:0]               nq_o,
  output logic [fpa_pkg::DataWidth-1:0] rem_o,
  output logic [fpa_pkg::DataWidth-1:0] den_o
);
  import fpa_pkg::*;

  logic                 valid_q;
  side_t                side_q;
  logic [NumW-1:0]      nq_d, nq_q;
  logic [DataWidth-1:0] rem_d, rem_q;
  logic [DataWidth-1:0] den_q;

  always_comb begin
    logic [DataWidth:0] rem_v;
    logic [NumW-1:0]    nq_v;
    rem_v = {1'b0, rem_i};
    nq_v  = nq_i;
    for (int k = 0; k < DivStepBits; k++) begin
      rem_v = {rem_v[DataWidth-1:0], nq_v[NumW-1]};
      nq_v  = {nq_v[NumW-2:0], 1'b0};
      if (rem_v >= {1'b0, den_i}) begin
        rem_v   = rem_v - {1'b0, den_i};
        nq_v[0] = 1'b1;
      end
    end
    rem_d = rem_v[DataWidth-1:0];
    nq_d  = nq_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side_q <= side_i;
      nq_q   <= nq_d;
      rem_q  <= rem_d;
      den_q  <= den_i;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign nq_o    = nq_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;

endmodule

FILE: rtl/fpa_out.sv
// ----------------------------------------------------------------------------
// fpa_out: quotient rounding, result select and output skid buffer
// Rounds to nearest with ties away from zero, applies the sign, and parts
// the pipeline from the response channel with an output and a skid register.
// ----------------------------------------------------------------------------
module fpa_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  fpa_pkg::side_t                side_i,
  input  logic [fpa_pkg::DataWidth-1:0] quo_i,
  input  logic [fpa_pkg::DataWidth-1:0] rem_i,
  input  logic [fpa_pkg::DataWidth-1:0] den_i,
  output logic                          adv_o,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output fpa_pkg::rsp_t                 rsp_word_o
);
  import fpa_pkg::*;

  logic                 round_up;
  logic [DataWidth-1:0] div_res;
  rsp_t                 word;
  logic                 take;
  logic                 out_valid_d, out_valid_q;
  rsp_t                 out_word_d, out_word_q;
  logic                 skid_valid_d, skid_valid_q;
  rsp_t                 skid_word_d, skid_word_q;

  assign round_up = ({rem_i, 1'b0} >= {1'b0, den_i});
  assign div_res  = side_i.neg ? (~quo_i + DataWidth'(!round_up))
                               : (quo_i + DataWidth'(round_up));

  always_comb begin
    word.result         = side_i.is_div ? data_t'(div_res) : side_i.res;
    word.condition      = side_i.cond;
    word.divide_by_zero = side_i.dz;
  end

  assign take  = !out_valid_q || rsp_ready_i;
  assign adv_o = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_word_d   = out_word_q;
    skid_valid_d = skid_valid_q;
    skid_word_d  = skid_word_q;
    if (take) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_word_d   = skid_word_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = valid_i;
        out_word_d  = word;
      end
    end else if (valid_i && !skid_valid_q) begin
      skid_valid_d = 1'b1;
      skid_word_d  = word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q  <= out_word_d;
    skid_word_q <= skid_word_d;
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_word_o  = out_word_q;

endmodule

FILE: rtl/fixed_point_alu_q24_8_core.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8_core: pipelined Q24.8 fixed-point ALU
// Divider: restoring stages retiring two quotient bits a stage.
// Throughput: one word per cycle while the skid buffer is empty; every
//   operation flows through all stages.
// Reset: asynchronous, active low; clears all valid bits and the skid buffer.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8_core #(
  parameter int unsigned FracBits = fpa_pkg::FracBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fpa_req_if.sink   req_i,
  fpa_rsp_if.source rsp_o
);
  import fpa_pkg::*;

  localparam int unsigned NumW      = ((DataWidth + FracBits + DivStepBits - 1) / DivStepBits)
                                      * DivStepBits;
  localparam int unsigned NumStages = NumW / DivStepBits;

  logic                          adv;
  logic                          prep_valid;
  side_t                         prep_side;
  logic                          prep_is_mul;
  logic signed [2*DataWidth-1:0] prep_prod;
  logic [NumW-1:0]               prep_num;
  logic [DataWidth-1:0]          prep_den;
  side_t                         stage0_side;

  logic                 valid_s [NumStages+1];
  side_t                side_s  [NumStages+1];
  logic [NumW-1:0]      nq_s    [NumStages+1];
  logic [DataWidth-1:0] rem_s   [NumStages+1];
  logic [DataWidth-1:0] den_s   [NumStages+1];
  rsp_t                 rsp_word;

  assign req_i.ready = adv;

  fpa_prep #(
    .FracBits (FracBits),
    .NumW     (NumW)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (req_i.valid),
    .operation_i (req_i.operation),
    .operand_a_i (req_i.operand_a),
    .operand_b_i (req_i.operand_b),
    .valid_o     (prep_valid),
    .side_o      (prep_side),
    .is_mul_o    (prep_is_mul),
    .prod_o      (prep_prod),
    .num_o       (prep_num),
    .den_o       (prep_den)
  );

  always_comb begin
    stage0_side = prep_side;
    if (prep_is_mul) begin
      stage0_side.res = data_t'(prep_prod[FracBits +: DataWidth]);
    end
  end

  assign valid_s[0] = prep_valid;
  assign side_s[0]  = stage0_side;
  assign nq_s[0]    = prep_num;
  assign rem_s[0]   = '0;
  assign den_s[0]   = prep_den;

  for (genvar g = 0; g < NumStages; g++) begin : g_div
    fpa_div_stage #(
      .NumW (NumW)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (valid_s[g]),
      .side_i  (side_s[g]),
      .nq_i    (nq_s[g]),
      .rem_i   (rem_s[g]),
      .den_i   (den_s[g]),
      .valid_o (valid_s[g+1]),
      .side_o  (side_s[g+1]),
      .nq_o    (nq_s[g+1]),
      .rem_o   (rem_s[g+1]),
      .den_o   (den_s[g+1])
    );
  end

  fpa_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_s[NumStages]),
    .side_i      (side_s[NumStages]),
    .quo_i       (nq_s[NumStages][DataWidth-1:0]),
    .rem_i       (rem_s[NumStages]),
    .den_i       (den_s[NumStages]),
    .adv_o       (adv),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_word_o  (rsp_word)
  );

  assign rsp_o.result         = rsp_word.result;
  assign rsp_o.condition      = rsp_word.condition;
  assign rsp_o.divide_by_zero = rsp_word.divide_by_zero;

endmodule

FILE: rtl/fpa_checker.sv
// ----------------------------------------------------------------------------
// fpa_checker: port-level assertions for the fixed-point ALU
// Watches the request and response channels; bound to the core.
// ----------------------------------------------------------------------------
module fpa_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  req_ready_i,
  input logic                  rsp_valid_i,
  input logic                  rsp_ready_i,
  input logic [31:0]           rsp_result_i,
  input logic                  rsp_condition_i,
  input logic                  rsp_divide_by_zero_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response valid dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_result_i) && $stable(rsp_condition_i)
                                    && $stable(rsp_divide_by_zero_i))
    else $error("response word changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_condition_i || rsp_divide_by_zero_i) |-> rsp_result_i == '0)
    else $error("comparison or zero-divisor word with nonzero result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready_i |-> $past(rsp_valid_i && !rsp_ready_i))
    else $error("request side stalled without a stalled response");

endmodule

bind fixed_point_alu_q24_8_core fpa_checker u_fpa_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .req_ready_i          (req_i.ready),
  .rsp_valid_i          (rsp_o.valid),
  .rsp_ready_i          (rsp_o.ready),
  .rsp_result_i         (rsp_o.result),
  .rsp_condition_i      (rsp_o.condition),
  .rsp_divide_by_zero_i (rsp_o.divide_by_zero)
);
